FILE: hw/rtl/sfp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and CRC helper for the sync/length/CRC-16 frame parser.
// No dependencies; used by every module of the parser.
package sfp_pkg;

  localparam int unsigned HeaderBytes = 9;
  localparam int unsigned QueueDepth  = 2;
  localparam logic [6:0]  HeaderEnd   = 7'd11;
  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPoly     = 16'h1021;
  localparam logic [15:0] CrcTop      = 16'h8000;

  typedef enum logic [1:0] {
    REG_FIRST_SYNC  = 2'd0,
    REG_SECOND_SYNC = 2'd1,
    REG_VERSION     = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LOAD
  } back_state_e;

  typedef struct packed {
    logic [7:0] first_sync;
    logic [7:0] second_sync;
    logic [7:0] version;
  } parser_cfg_t;

  typedef struct packed {
    logic [7:0]  version;
    logic [7:0]  ftype;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [6:0]  len;
  } frame_desc_t;

  typedef struct packed {
    logic       en;
    logic       bank;
    logic [5:0] idx;
    logic [7:0] data;
  } pay_wr_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcTop) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/sfp_front.sv
`timescale 1ns / 1ps
// Front end: sync hunt, header capture, running CRC, payload writes and frame commit.
// Depends on sfp_pkg.
module sfp_front #(
  parameter int unsigned MaxPayloadBytes = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfp_pkg::parser_cfg_t cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 q_full_i,
  input  logic                 q_bank_i,
  output logic                 push_o,
  output sfp_pkg::frame_desc_t desc_o,
  output sfp_pkg::pay_wr_t     wr_o
);

  logic        active_q, active_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [6:0]  len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  hdr_q [sfp_pkg::HeaderBytes];
  logic [7:0]  crcl_q;
  logic        hdr_we, crcl_we, accept;
  logic [6:0]  pos;
  logic [3:0]  hdr_idx;
  logic [15:0] len16;
  logic [6:0]  pay_idx;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign pos        = cnt_q + 7'd1;
  assign hdr_idx    = 4'(pos - 7'd3);
  assign len16      = {in_byte_i, hdr_q[7]};
  assign pay_idx    = pos - sfp_pkg::HeaderEnd - 7'd1;

  assign desc_o.version = hdr_q[0];
  assign desc_o.ftype   = hdr_q[1];
  assign desc_o.flags   = hdr_q[2];
  assign desc_o.seq     = {hdr_q[6], hdr_q[5], hdr_q[4], hdr_q[3]};
  assign desc_o.len     = len_q;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    crc_d    = crc_q;
    hdr_we   = 1'b0;
    crcl_we  = 1'b0;
    push_o   = 1'b0;
    wr_o     = '0;
    if (accept) begin
      if (!active_q) begin
        if (in_byte_i == cfg_i.first_sync) begin
          active_d = 1'b1;
          cnt_d    = 7'd1;
          len_d    = '0;
          crc_d    = sfp_pkg::CrcInit;
        end
      end else begin
        cnt_d = pos;
        if (pos == 7'd2) begin
          if (in_byte_i != cfg_i.second_sync) begin
            len_d = '0;
            crc_d = sfp_pkg::CrcInit;
            if (in_byte_i == cfg_i.first_sync) begin
              cnt_d = 7'd1;
            end else begin
              active_d = 1'b0;
              cnt_d    = '0;
            end
          end
        end else if (pos <= sfp_pkg::HeaderEnd) begin
          hdr_we = 1'b1;
          crc_d  = sfp_pkg::crc_byte(crc_q, in_byte_i);
          if (pos == sfp_pkg::HeaderEnd) begin
            if (hdr_q[0] != cfg_i.version || len16 > 16'(MaxPayloadBytes)) begin
              active_d = 1'b0;
              cnt_d    = '0;
              len_d    = '0;
              crc_d    = sfp_pkg::CrcInit;
            end else begin
              len_d = len16[6:0];
            end
          end
        end else if (pos <= sfp_pkg::HeaderEnd + len_q) begin
          wr_o.en   = 1'b1;
          wr_o.bank = q_bank_i;
          wr_o.idx  = pay_idx[5:0];
          wr_o.data = in_byte_i;
          crc_d     = sfp_pkg::crc_byte(crc_q, in_byte_i);
        end else if (pos == sfp_pkg::HeaderEnd + len_q + 7'd1) begin
          crcl_we = 1'b1;
        end else begin
          push_o   = ({in_byte_i, crcl_q} == crc_q);
          active_d = 1'b0;
          cnt_d    = '0;
          len_d    = '0;
          crc_d    = sfp_pkg::CrcInit;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      len_q    <= '0;
      crc_q    <= sfp_pkg::CrcInit;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hdr_idx] <= in_byte_i;
    end
    if (crcl_we) begin
      crcl_q <= in_byte_i;
    end
  end

endmodule

FILE: hw/rtl/sfp_queue.sv
`timescale 1ns / 1ps
// Two-slot queue of committed frame descriptors; slot index doubles as payload bank.
// Depends on sfp_pkg.
module sfp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sfp_pkg::frame_desc_t desc_i,
  input  logic                 pop_i,
  output sfp_pkg::frame_desc_t head_o,
  output logic                 full_o,
  output logic                 empty_o,
  output logic                 wr_ptr_o,
  output logic                 rd_ptr_o
);

  sfp_pkg::frame_desc_t slot_q [sfp_pkg::QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o   = (cnt_q == 2'(sfp_pkg::QueueDepth));
  assign empty_o  = (cnt_q == 2'd0);
  assign wr_ptr_o = wr_ptr_q;
  assign rd_ptr_o = rd_ptr_q;
  assign head_o   = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= desc_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

FILE: hw/rtl/sfp_back.sv
`timescale 1ns / 1ps
// Back end: double-banked payload memory and result sequencer with output register.
// Depends on sfp_pkg.
module sfp_back #(
  parameter int unsigned MaxPayloadBytes = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfp_pkg::pay_wr_t     wr_i,
  input  sfp_pkg::frame_desc_t desc_i,
  input  logic                 empty_i,
  input  logic                 bank_i,
  output logic                 pop_o,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [79:0]          m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);

  localparam int unsigned IdxW  = (MaxPayloadBytes > 1) ? $clog2(MaxPayloadBytes) : 1;
  localparam int unsigned Depth = 2 * (1 << IdxW);

  logic [7:0]  mem_q [Depth];
  logic [7:0]  rd_q;
  sfp_pkg::back_state_e state_q, state_d;
  logic [5:0]  k_q, k_d;
  logic        tvalid_q, tvalid_d;
  logic [79:0] tdata_q;
  logic        tuser_q, tlast_q;
  logic        load, last, present;
  logic [7:0]  pay;

  assign present  = (desc_i.len != 7'd0);
  assign last     = !present || (({1'b0, k_q} + 7'd1) == desc_i.len);
  assign pay      = present ? rd_q : 8'h00;
  assign m_tvalid = tvalid_q;
  assign m_tdata  = tdata_q;
  assign m_tuser  = tuser_q;
  assign m_tlast  = tlast_q;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    unique case (state_q)
      sfp_pkg::BK_IDLE: begin
        if (!empty_i) begin
          k_d     = '0;
          state_d = sfp_pkg::BK_READ;
        end
      end
      sfp_pkg::BK_READ: begin
        state_d = sfp_pkg::BK_LOAD;
      end
      sfp_pkg::BK_LOAD: begin
        if (!tvalid_q || m_tready) begin
          load = 1'b1;
          if (last) begin
            pop_o   = 1'b1;
            state_d = sfp_pkg::BK_IDLE;
          end else begin
            k_d     = k_q + 6'd1;
            state_d = sfp_pkg::BK_READ;
          end
        end
      end
      default: state_d = sfp_pkg::BK_IDLE;
    endcase
    if (load) begin
      tvalid_d = 1'b1;
    end else if (m_tready) begin
      tvalid_d = 1'b0;
    end else begin
      tvalid_d = tvalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sfp_pkg::BK_IDLE;
      k_q      <= '0;
      tvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      tvalid_q <= tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[{wr_i.bank, wr_i.idx[IdxW-1:0]}] <= wr_i.data;
    end
    rd_q <= mem_q[{bank_i, k_q[IdxW-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tdata_q <= {3'b000, pay, k_q, desc_i.len, desc_i.seq,
                  desc_i.flags, desc_i.ftype, desc_i.version};
      tuser_q <= present;
      tlast_q <= last;
    end
  end

  a_busy_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sfp_pkg::BK_IDLE) |-> !empty_i) else $error("sequencer busy without frame");
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (tvalid_q && tlast_q)) else $error("frame popped without last result");
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sfp_pkg::BK_LOAD && present) |-> ({1'b0, k_q} < desc_i.len))
    else $error("byte position beyond payload");

endmodule

FILE: hw/rtl/sync_length_crc16_frame_parser.sv
`timescale 1ns / 1ps
// Top level of the sync/length/CRC-16 frame parser: config registers and the
// front, queue and back instances. Depends on sfp_pkg, sfp_front, sfp_queue, sfp_back.
//
// Channel  | Direction | Handshake                  | Contents
// s_*      | in        | s_tvalid / s_tready        | tdata[7:0] rx_byte
// m_*      | out       | m_tvalid / m_tready        | tdata frame fields, tuser byte_present,
//          |           |                            | tlast last_of_frame
// APB      | in        | psel & penable & pwrite    | 0x0 first sync, 0x4 second sync,
//          |           |                            | 0x8 accepted version
//
// Input takes one byte per cycle; s_tready drops only while both queue slots hold
// committed frames not yet drained.
// A frame is committed to the queue with its last CRC byte; an idle back end then passes
// through READ, for the registered payload memory read, and LOAD for every result.
// Reset clears control state and loads the register defaults; no clearing pass.
// A stalled m_tready holds the output register; the front keeps parsing until both queue slots fill.
module sync_length_crc16_frame_parser #(
  parameter int unsigned MaxPayloadBytes = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] frame_version, [15:8] type_code, [23:16] frame_flags,
  // [55:24] sequence_number, [62:56] payload_count, [68:63] byte_position,
  // [76:69] payload_byte, [79:77] zero
  output logic [79:0] m_tdata,
  output logic        m_tuser,   // [0] byte_present
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sfp_pkg::parser_cfg_t cfg_q;
  sfp_pkg::frame_desc_t push_desc, head_desc;
  sfp_pkg::pay_wr_t     pay_wr;
  sfp_pkg::reg_idx_e    reg_idx;
  logic push, pop, q_full, q_empty, wr_ptr, rd_ptr;

  assign pready  = 1'b1;
  assign reg_idx = sfp_pkg::reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (reg_idx)
      sfp_pkg::REG_FIRST_SYNC:  prdata = {24'h0, cfg_q.first_sync};
      sfp_pkg::REG_SECOND_SYNC: prdata = {24'h0, cfg_q.second_sync};
      sfp_pkg::REG_VERSION:     prdata = {24'h0, cfg_q.version};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_sync  <= 8'hA5;
      cfg_q.second_sync <= 8'h5A;
      cfg_q.version     <= 8'h01;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        sfp_pkg::REG_FIRST_SYNC:  cfg_q.first_sync  <= pwdata[7:0];
        sfp_pkg::REG_SECOND_SYNC: cfg_q.second_sync <= pwdata[7:0];
        sfp_pkg::REG_VERSION:     cfg_q.version     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  sfp_front #(
    .MaxPayloadBytes(MaxPayloadBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .in_byte_i  (s_tdata),
    .q_full_i   (q_full),
    .q_bank_i   (wr_ptr),
    .push_o     (push),
    .desc_o     (push_desc),
    .wr_o       (pay_wr)
  );

  sfp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .desc_i   (push_desc),
    .pop_i    (pop),
    .head_o   (head_desc),
    .full_o   (q_full),
    .empty_o  (q_empty),
    .wr_ptr_o (wr_ptr),
    .rd_ptr_o (rd_ptr)
  );

  sfp_back #(
    .MaxPayloadBytes(MaxPayloadBytes)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (pay_wr),
    .desc_i   (head_desc),
    .empty_i  (q_empty),
    .bank_i   (rd_ptr),
    .pop_o    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: tb/sync_length_crc16_frame_parser_test.sv
`timescale 1ns / 1ps
// Testbench for the sync/length/CRC-16 frame parser: a stream driver and a result
// monitor around the block, checked against an in-bench parser model. Depends on sfp_pkg.
module sync_length_crc16_frame_parser_test;

  localparam int unsigned MaxPayload = 64;
  localparam logic [3:0]  UnusedRegAddr = 4'hC;

  typedef struct packed {
    logic [7:0]  version;
    logic [7:0]  ftype;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [6:0]  count;
    logic [5:0]  index;
    logic [7:0]  data;
    logic        present;
    logic        last;
  } frame_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;  // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [7:0] version, [15:8] type, [23:16] flags, [55:24] seq, [62:56] count,
  // [68:63] position, [76:69] payload byte, [79:77] zero
  logic [79:0] m_tdata;
  logic        m_tuser;          // [0] byte_present
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  sync_length_crc16_frame_parser #(
    .MaxPayloadBytes(MaxPayload)
  ) dut (
    .clk_i, .rst_ni,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  // parser model state and register copy
  logic [7:0]  sync_a = 8'hA5;
  logic [7:0]  sync_b = 8'h5A;
  logic [7:0]  want_version = 8'h01;
  bit          in_frame = 1'b0;
  logic [6:0]  frame_pos = '0;
  logic [6:0]  frame_total = '0;
  logic [15:0] crc_acc = sfp_pkg::CrcInit;
  logic [7:0]  hdr_bytes [sfp_pkg::HeaderBytes];
  logic [7:0]  crc_lo;
  logic [7:0]  pay_bytes [MaxPayload];

  logic [7:0]  link_bytes [$];
  frame_beat_t pending_beats [$];
  int unsigned queued_total = 0;
  int unsigned mismatch_count = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;

  function automatic logic [15:0] crc_ccitt(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] r;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      if (r[15] ^ d[i]) begin
        r = {r[14:0], 1'b0} ^ sfp_pkg::CrcPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic string fmt_beat(input frame_beat_t b);
    return $sformatf("ver %h typ %h flg %h seq %h cnt %0d pos %0d byte %h pr %b last %b",
                     b.version, b.ftype, b.flags, b.seq, b.count, b.index, b.data,
                     b.present, b.last);
  endfunction

  task automatic reset_hunt(input bit opened);
    in_frame    = opened;
    frame_pos   = opened ? 7'd1 : 7'd0;
    frame_total = '0;
    crc_acc     = sfp_pkg::CrcInit;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [6:0]  pos;
    int unsigned plen;
    int unsigned n;
    frame_beat_t beat;
    if (!in_frame) begin
      if (b == sync_a) reset_hunt(1'b1);
      return;
    end
    frame_pos = frame_pos + 7'd1;
    pos = frame_pos;
    if (pos == 7'd2) begin
      if (b != sync_b) reset_hunt(b == sync_a);
      return;
    end
    if (pos <= sfp_pkg::HeaderEnd) begin
      hdr_bytes[pos - 7'd3] = b;
      crc_acc = crc_ccitt(crc_acc, b);
      if (pos == sfp_pkg::HeaderEnd) begin
        plen = {hdr_bytes[8], hdr_bytes[7]};
        if (hdr_bytes[0] != want_version || plen > MaxPayload) begin
          reset_hunt(1'b0);
          return;
        end
        frame_total = 7'(sfp_pkg::HeaderEnd + plen + 2);
      end
      return;
    end
    plen = frame_total - sfp_pkg::HeaderEnd - 2;
    if (pos <= sfp_pkg::HeaderEnd + plen) begin
      pay_bytes[pos - sfp_pkg::HeaderEnd - 1] = b;
      crc_acc = crc_ccitt(crc_acc, b);
      return;
    end
    if (pos == sfp_pkg::HeaderEnd + plen + 1) begin
      crc_lo = b;
      return;
    end
    if ({b, crc_lo} == crc_acc) begin
      n = (plen == 0) ? 1 : plen;
      for (int k = 0; k < n; k++) begin
        beat.version = hdr_bytes[0];
        beat.ftype   = hdr_bytes[1];
        beat.flags   = hdr_bytes[2];
        beat.seq     = {hdr_bytes[6], hdr_bytes[5], hdr_bytes[4], hdr_bytes[3]};
        beat.count   = 7'(plen);
        beat.index   = 6'(k);
        beat.data    = (plen == 0) ? 8'h00 : pay_bytes[k];
        beat.present = (plen != 0);
        beat.last    = (k == n - 1);
        pending_beats.push_back(beat);
      end
    end
    reset_hunt(1'b0);
  endtask

  // driver: present the next link byte, hold it until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) parse_rx_byte(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0 || link_bytes.size() == 0) begin
          if (tx_gap != 0) tx_gap--;
          s_tvalid <= 1'b0;
        end else begin
          s_tdata  <= link_bytes.pop_front();
          s_tvalid <= 1'b1;
          if (tx_idle_en && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 11);
        end
      end
    end
  end

  // monitor: compare each accepted result with the oldest pending beat
  always @(posedge clk_i) begin
    frame_beat_t want;
    frame_beat_t got;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[55:24],
                m_tdata[62:56], m_tdata[68:63], m_tdata[76:69], m_tuser, m_tlast};
        if (pending_beats.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("result with nothing pending: %s", fmt_beat(got));
        end else begin
          want = pending_beats.pop_front();
          if (got.version != want.version || got.ftype != want.ftype ||
              got.flags != want.flags || got.seq != want.seq ||
              got.count != want.count || got.index != want.index ||
              got.data != want.data || got.present != want.present ||
              got.last != want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result mismatch, expected %s", fmt_beat(want));
              $display("                 actual   %s", fmt_beat(got));
            end
          end
        end
      end
      if (rx_gap != 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (rx_idle_en && $urandom_range(0, 9) == 0) rx_gap = $urandom_range(1, 11);
      end
    end
  end

  function automatic logic [3:0] reg_addr(input sfp_pkg::reg_idx_e r);
    return {r, 2'b00};
  endfunction

  task automatic write_reg(input logic [3:0] addr, input logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == reg_addr(sfp_pkg::REG_FIRST_SYNC)) sync_a = value;
    else if (addr == reg_addr(sfp_pkg::REG_SECOND_SYNC)) sync_b = value;
    else if (addr == reg_addr(sfp_pkg::REG_VERSION)) want_version = value;
  endtask

  task automatic set_regs(input logic [7:0] first, second, version);
    write_reg(reg_addr(sfp_pkg::REG_FIRST_SYNC), first);
    write_reg(reg_addr(sfp_pkg::REG_SECOND_SYNC), second);
    write_reg(reg_addr(sfp_pkg::REG_VERSION), version);
  endtask

  task automatic push_rx(input logic [7:0] b);
    link_bytes.push_back(b);
    queued_total++;
  endtask

  task automatic queue_frame(input logic [7:0] ver, typ, flg, input logic [31:0] seq,
                             input logic [15:0] plen, input bit bad_crc,
                             input bit dup_sync);
    logic [7:0]  hdr [sfp_pkg::HeaderBytes];
    logic [7:0]  b;
    logic [15:0] crc;
    crc = sfp_pkg::CrcInit;
    push_rx(sync_a);
    if (dup_sync) push_rx(sync_a);
    push_rx(sync_b);
    hdr = '{ver, typ, flg, seq[7:0], seq[15:8], seq[23:16], seq[31:24],
            plen[7:0], plen[15:8]};
    foreach (hdr[i]) begin
      push_rx(hdr[i]);
      crc = crc_ccitt(crc, hdr[i]);
    end
    if (plen > MaxPayload) return;
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom_range(0, 255));
      push_rx(b);
      crc = crc_ccitt(crc, b);
    end
    if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
    push_rx(crc[7:0]);
    push_rx(crc[15:8]);
  endtask

  task automatic queue_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    logic [7:0]  ver;
    logic [15:0] plen;
    start = queued_total;
    while (queued_total - start < n_bytes) begin
      pick = $urandom_range(0, 9);
      plen = ($urandom_range(0, 11) == 0) ? 16'($urandom_range(9, MaxPayload))
                                          : 16'($urandom_range(0, 8));
      ver = want_version;
      if (pick == 0) begin
        if ($urandom_range(0, 1) == 0) push_rx(sync_a);
        repeat ($urandom_range(1, 4)) push_rx(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        case ($urandom_range(0, 2))
          0: queue_frame(ver ^ 8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom),
                         $urandom, plen, 1'b0, 1'b0);
          1: queue_frame(ver, 8'($urandom), 8'($urandom), $urandom,
                         16'($urandom_range(MaxPayload + 1, 65535)), 1'b0, 1'b0);
          default: queue_frame(ver, 8'($urandom), 8'($urandom), $urandom, plen,
                               1'b1, 1'b0);
        endcase
      end else begin
        queue_frame(ver, 8'($urandom), 8'($urandom), $urandom, plen, 1'b0,
                    $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic drain();
    while (link_bytes.size() != 0 || s_tvalid) @(posedge clk_i);
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_regs(8'hA5, 8'h5A, 8'h01);
    write_reg(UnusedRegAddr, 8'h3C);

    queue_frame(8'h01, 8'hFF, 8'h00, 32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0);
    queue_frame(8'h01, 8'h00, 8'hFF, 32'h0000_0000, 16'd1, 1'b0, 1'b1);
    push_rx(8'hA5);
    push_rx(8'h33);
    queue_frame(8'h02, 8'h11, 8'h22, 32'h1234_5678, 16'd0, 1'b0, 1'b0);
    queue_frame(8'h01, 8'h11, 8'h22, 32'h8765_4321, 16'd65, 1'b0, 1'b0);
    queue_frame(8'h01, 8'h33, 8'h44, 32'h0BAD_F00D, 16'd1, 1'b1, 1'b0);
    queue_frame(8'h01, 8'h80, 8'h7F, 32'h8000_0001, 16'd64, 1'b0, 1'b0);
    drain();

    set_regs(8'h00, 8'hFF, 8'hFF);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    queue_traffic(90);
    drain();

    set_regs(8'h7E, 8'h7E, 8'h00);
    rx_idle_en = 1'b0;
    queue_frame(8'h00, 8'h01, 8'h02, 32'h0102_0304, 16'd3, 1'b0, 1'b1);
    queue_traffic(80);
    drain();

    set_regs(8'($urandom), 8'($urandom), 8'($urandom));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    queue_traffic(70);
    drain();

    set_regs(8'hFF, 8'h00, 8'h80);
    rx_idle_en = 1'b0;
    queue_traffic(40);
    drain();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
